// File: rtl/core/ugb_pkg.sv
// Shared types, codes and defaults for the uniform grid box binning core.
// Used by every module under rtl/core except ugb_ram; depends on nothing.
`timescale 1ns / 1ps

package ugb_pkg;

    localparam int COORD_BITS        = 32;
    localparam int IDX_BITS          = 10;
    localparam int DEF_GRID_SIZE     = 16;
    localparam int DEF_MAX_BOXES     = 1024;
    localparam int DEF_CELL_CAPACITY = 16;
    localparam int CMDQ_DEPTH        = 4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_INSIDE  = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_NOGRID  = 2'd2;

    typedef struct packed {
        logic                         operation;
        logic signed [COORD_BITS-1:0] box_x_min;
        logic signed [COORD_BITS-1:0] box_x_max;
        logic signed [COORD_BITS-1:0] box_y_min;
        logic signed [COORD_BITS-1:0] box_y_max;
        logic                         last_box;
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
    } t_item;

    typedef struct packed {
        logic [3:0]          cell_x;
        logic [3:0]          cell_y;
        logic [1:0]          status;
        logic [IDX_BITS-1:0] box_index;
        logic                cell_empty;
        logic                cell_overflowed;
        logic                last_result;
    } t_result;

    // Classified command; for a query c0/c1 carry the point.
    typedef struct packed {
        logic [1:0]                   kind;
        logic signed [COORD_BITS-1:0] c0;
        logic signed [COORD_BITS-1:0] c1;
        logic signed [COORD_BITS-1:0] c2;
        logic signed [COORD_BITS-1:0] c3;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic neg;
        logic big;
    } t_div_stat;

endpackage

// File: rtl/core/ugb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module ugb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/core/ugb_div.sv
// Bit-serial divider: |num * GRID_SIZE| / den, one quotient bit per cycle.
// Depends on ugb_pkg.
`timescale 1ns / 1ps

module ugb_div #(
    parameter int GRID_SIZE = ugb_pkg::DEF_GRID_SIZE
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [ugb_pkg::COORD_BITS+1:0] i_num,
    input  logic [ugb_pkg::COORD_BITS-1:0]     i_den,
    output ugb_pkg::t_div_stat                 o_stat,
    output logic [$clog2(GRID_SIZE)-1:0]       o_q
);
    import ugb_pkg::*;

    localparam int DW = COORD_BITS + 2;
    localparam int GB = $clog2(GRID_SIZE) + 1;
    localparam int NW = DW + GB;
    localparam int IW = $clog2(GRID_SIZE);
    localparam int KW = $clog2(NW + 1);

    logic [DW-1:0]         w_abs;
    logic [GB-1:0]         w_g;
    logic [NW-1:0]         w_mag;
    logic [COORD_BITS:0]   w_sh;
    logic [COORD_BITS:0]   w_diff;
    logic                  w_ge;
    logic                  w_big;

    logic                  r_busy;
    logic                  r_done;
    logic [KW-1:0]         r_cnt;
    logic [NW-1:0]         r_mag;
    logic [NW-1:0]         r_quo;
    logic [COORD_BITS:0]   r_rem;
    logic [COORD_BITS-1:0] r_den;
    logic                  r_neg;

    assign w_abs  = i_num[DW-1] ? DW'(-i_num) : DW'(i_num);
    assign w_g    = GB'(GRID_SIZE);
    assign w_mag  = w_abs * w_g;
    // The remainder stays below the divisor, so its top bit is always clear.
    assign w_sh   = {r_rem[COORD_BITS-1:0], r_mag[NW-1]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign w_ge   = (w_sh >= {1'b0, r_den});
    assign w_big  = (r_quo >= NW'(GRID_SIZE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= KW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= w_mag;
            r_neg <= i_num[DW-1];
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_mag <= {r_mag[NW-2:0], 1'b0};
            r_rem <= w_ge ? w_diff : w_sh;
            r_quo <= {r_quo[NW-2:0], w_ge};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.neg  = r_neg && (r_quo != '0);
    assign o_stat.big  = w_big;
    assign o_q         = w_big ? IW'(GRID_SIZE - 1) : r_quo[IW-1:0];

endmodule

// File: rtl/core/ugb_front.sv
// Front end: accepts input words, classifies them into commands and queues them.
// Depends on ugb_pkg.
`timescale 1ns / 1ps

module ugb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  ugb_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_avail,
    output ugb_pkg::t_cmd  o_cmd
);
    import ugb_pkg::*;

    localparam int PW = $clog2(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    t_cmd          r_mem [CMDQ_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    t_cmd          w_cmd;
    logic          w_push;
    logic          w_pop;

    always_comb begin
        w_cmd = '0;
        if (i_item.operation == OP_QUERY) begin
            w_cmd.kind = CMD_QUERY;
            w_cmd.c0   = i_item.query_x;
            w_cmd.c1   = i_item.query_y;
        end else begin
            w_cmd.kind = i_item.last_box ? CMD_BUILD : CMD_LOAD;
            w_cmd.c0   = i_item.box_x_min;
            w_cmd.c1   = i_item.box_x_max;
            w_cmd.c2   = i_item.box_y_min;
            w_cmd.c3   = i_item.box_y_max;
        end
    end

    assign full    = (r_cnt == CW'(CMDQ_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign w_push  = push && !full;
    assign w_pop   = i_take && o_avail;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_cmd;
        end
    end

endmodule

// File: rtl/core/ugb_back.sv
// Back end: box store, grid build, query lookup and the result register.
// Depends on ugb_pkg, ugb_ram and ugb_div.
`timescale 1ns / 1ps

module ugb_back #(
    parameter int GRID_SIZE     = ugb_pkg::DEF_GRID_SIZE,
    parameter int MAX_BOXES     = ugb_pkg::DEF_MAX_BOXES,
    parameter int CELL_CAPACITY = ugb_pkg::DEF_CELL_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    output logic             o_take,
    input  ugb_pkg::t_cmd    i_cmd,
    output logic             empty,
    input  logic             pop,
    output ugb_pkg::t_result o_result
);
    import ugb_pkg::*;

    localparam int NC   = GRID_SIZE * GRID_SIZE;
    localparam int CAW  = $clog2(NC);
    localparam int IW   = $clog2(GRID_SIZE);
    localparam int LD   = NC * CELL_CAPACITY;
    localparam int LAW  = $clog2(LD);
    localparam int BAW  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNTW = $clog2(MAX_BOXES + 1);
    localparam int FCW  = $clog2(CELL_CAPACITY + 1);
    localparam int KW   = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
    localparam int DW   = COORD_BITS + 2;
    localparam int SW   = COORD_BITS + 1;
    localparam int BW   = 4 * COORD_BITS;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CLR  = 5'd1;
    localparam logic [4:0] S_URD  = 5'd2;
    localparam logic [4:0] S_UMRG = 5'd3;
    localparam logic [4:0] S_UFIN = 5'd4;
    localparam logic [4:0] S_BRD  = 5'd5;
    localparam logic [4:0] S_BWT  = 5'd6;
    localparam logic [4:0] S_DIV  = 5'd7;
    localparam logic [4:0] S_DWT  = 5'd8;
    localparam logic [4:0] S_BCHK = 5'd9;
    localparam logic [4:0] S_CRD  = 5'd10;
    localparam logic [4:0] S_CWT  = 5'd11;
    localparam logic [4:0] S_QF   = 5'd12;
    localparam logic [4:0] S_QFW  = 5'd13;
    localparam logic [4:0] S_QL   = 5'd14;
    localparam logic [4:0] S_QLW  = 5'd15;
    localparam logic [4:0] S_EMIT = 5'd16;

    function automatic logic signed [DW-1:0] sx(input logic signed [COORD_BITS-1:0] v);
        return {{2{v[COORD_BITS-1]}}, v};
    endfunction

    logic [4:0]                   r_state;
    logic [CNTW-1:0]              r_count;
    logic                         r_ready;
    logic [BAW-1:0]               r_i;
    logic [CAW-1:0]               r_clr;
    logic signed [COORD_BITS-1:0] r_org_x, r_org_y, r_max_x, r_max_y;
    logic signed [SW-1:0]         r_span_x, r_span_y;
    logic signed [COORD_BITS-1:0] r_bx0, r_bx1, r_by0, r_by1;
    logic [1:0]                   r_ph;
    logic                         r_isq;
    logic                         r_outside;
    logic [IW-1:0]                r_lx, r_rx, r_ly, r_ry, r_cx, r_cy;
    logic [FCW-1:0]               r_n;
    logic                         r_flag;
    logic [KW-1:0]                r_k;
    t_result                      r_res;
    t_result                      r_out;
    logic                         r_out_vld;

    logic [BW-1:0]                w_box_rd;
    logic [FCW:0]                 w_fill_rd;
    logic [IDX_BITS-1:0]          w_list_rd;
    logic                         w_box_we;
    logic [CNTW-1:0]              w_eff;
    logic                         w_fill_we;
    logic [CAW-1:0]               w_fill_wa;
    logic [FCW:0]                 w_fill_wd;
    logic                         w_list_we;
    logic [LAW-1:0]               w_list_wa;
    logic [LAW-1:0]               w_list_ra;
    logic [CAW-1:0]               w_cell;
    logic [FCW-1:0]               w_fill;
    logic                         w_axis_y;
    logic                         w_right;
    logic signed [SW-1:0]         w_span;
    logic                         w_span_pos;
    logic signed [COORD_BITS-1:0] w_p, w_m;
    logic signed [DW-1:0]         w_d;
    logic                         w_neq;
    logic                         w_div_start;
    t_div_stat                    w_div;
    logic [IW-1:0]                w_div_q;
    logic [IW-1:0]                w_idx;
    logic                         w_oflag;
    logic                         w_store;
    logic                         w_last_ph;
    logic                         w_last_box;
    logic                         w_emit;
    logic signed [COORD_BITS-1:0] w_x0, w_x1, w_y0, w_y1;

    assign w_x0 = w_box_rd[4*COORD_BITS-1:3*COORD_BITS];
    assign w_x1 = w_box_rd[3*COORD_BITS-1:2*COORD_BITS];
    assign w_y0 = w_box_rd[2*COORD_BITS-1:COORD_BITS];
    assign w_y1 = w_box_rd[COORD_BITS-1:0];

    assign w_eff    = r_ready ? '0 : r_count;
    assign w_box_we = (r_state == S_IDLE) && i_avail && (i_cmd.kind != CMD_QUERY)
                      && (w_eff < CNTW'(MAX_BOXES));

    assign w_cell    = CAW'(CAW'(r_cx) * CAW'(GRID_SIZE)) + CAW'(r_cy);
    assign w_fill    = w_fill_rd[FCW-1:0];
    assign w_list_ra = LAW'(LAW'(w_cell) * LAW'(CELL_CAPACITY)) + LAW'(r_k);
    assign w_list_wa = LAW'(LAW'(w_cell) * LAW'(CELL_CAPACITY)) + LAW'(w_fill[KW-1:0]);
    assign w_list_we = (r_state == S_CWT) && (w_fill < FCW'(CELL_CAPACITY));

    always_comb begin
        w_fill_we = 1'b0;
        w_fill_wa = w_cell;
        w_fill_wd = '0;
        if (r_state == S_CLR) begin
            w_fill_we = 1'b1;
            w_fill_wa = r_clr;
        end else if (r_state == S_CWT) begin
            w_fill_we = 1'b1;
            w_fill_wd = w_list_we ? {w_fill_rd[FCW], w_fill + 1'b1} : {1'b1, w_fill};
        end
    end

    // Operand selection: left edges and queries measure from the origin,
    // right edges measure back from the union maximum.
    assign w_axis_y   = r_isq ? r_ph[0] : r_ph[1];
    assign w_right    = !r_isq && r_ph[0];
    assign w_span     = w_axis_y ? r_span_y : r_span_x;
    assign w_span_pos = !w_span[SW-1] && (w_span != '0);
    assign w_p        = w_right ? (w_axis_y ? r_max_y : r_max_x) : (w_axis_y ? r_by0 : r_bx0);
    assign w_m        = w_right ? (w_axis_y ? r_by1 : r_bx1) : (w_axis_y ? r_org_y : r_org_x);
    assign w_d        = sx(w_p) - sx(w_m) - DW'(!r_isq);
    assign w_neq      = (w_p != w_m);
    assign w_div_start = (r_state == S_DIV) && w_span_pos;

    always_comb begin
        w_idx   = '0;
        w_oflag = w_neq;
        if (w_span_pos) begin
            w_oflag = w_div.neg || w_div.big;
            if (w_right) begin
                if (w_div.neg) begin
                    w_idx = IW'(GRID_SIZE - 1);
                end else if (w_div.big) begin
                    w_idx = '0;
                end else begin
                    w_idx = IW'(GRID_SIZE - 1) - w_div_q;
                end
            end else begin
                w_idx = w_div.neg ? '0 : w_div_q;
            end
        end
    end

    assign w_store    = ((r_state == S_DIV) && !w_span_pos) || ((r_state == S_DWT) && w_div.done);
    assign w_last_ph  = r_isq ? (r_ph == 2'd1) : (r_ph == 2'd3);
    assign w_last_box = (CNTW'(r_i) + 1'b1 == r_count);
    assign w_emit     = (r_state == S_EMIT) && (!r_out_vld || pop);
    assign o_take     = (r_state == S_IDLE) && i_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ready   <= 1'b0;
            r_out_vld <= 1'b0;
            r_org_x   <= '0;
            r_org_y   <= '0;
            r_span_x  <= '0;
            r_span_y  <= '0;
        end else begin
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (pop) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        if (i_cmd.kind == CMD_QUERY) begin
                            if (!r_ready) begin
                                r_res   <= '{4'd0, 4'd0, ST_NOGRID, '0, 1'b1, 1'b0, 1'b1};
                                r_state <= S_EMIT;
                            end else begin
                                r_bx0     <= i_cmd.c0;
                                r_by0     <= i_cmd.c1;
                                r_ph      <= 2'd0;
                                r_isq     <= 1'b1;
                                r_outside <= 1'b0;
                                r_state   <= S_DIV;
                            end
                        end else begin
                            r_ready <= 1'b0;
                            r_count <= w_box_we ? w_eff + 1'b1 : w_eff;
                            if (i_cmd.kind == CMD_BUILD) begin
                                r_clr   <= '0;
                                r_state <= S_CLR;
                            end
                        end
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CAW'(NC - 1)) begin
                        r_i     <= '0;
                        r_state <= S_URD;
                    end
                end
                S_URD: begin
                    r_state <= S_UMRG;
                end
                S_UMRG: begin
                    if (r_i == '0 || w_x0 < r_org_x) r_org_x <= w_x0;
                    if (r_i == '0 || w_x1 > r_max_x) r_max_x <= w_x1;
                    if (r_i == '0 || w_y0 < r_org_y) r_org_y <= w_y0;
                    if (r_i == '0 || w_y1 > r_max_y) r_max_y <= w_y1;
                    if (w_last_box) begin
                        r_state <= S_UFIN;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_URD;
                    end
                end
                S_UFIN: begin
                    r_span_x <= {r_max_x[COORD_BITS-1], r_max_x} - {r_org_x[COORD_BITS-1], r_org_x};
                    r_span_y <= {r_max_y[COORD_BITS-1], r_max_y} - {r_org_y[COORD_BITS-1], r_org_y};
                    r_i      <= '0;
                    r_state  <= S_BRD;
                end
                S_BRD: begin
                    r_state <= S_BWT;
                end
                S_BWT: begin
                    r_bx0   <= w_x0;
                    r_bx1   <= w_x1;
                    r_by0   <= w_y0;
                    r_by1   <= w_y1;
                    r_ph    <= 2'd0;
                    r_isq   <= 1'b0;
                    r_state <= S_DIV;
                end
                S_DIV, S_DWT: begin
                    if (r_state == S_DIV && w_span_pos) begin
                        r_state <= S_DWT;
                    end
                    if (w_store) begin
                        if (r_isq) begin
                            if (r_ph[0]) r_cy <= w_idx;
                            else         r_cx <= w_idx;
                            r_outside <= r_outside || w_oflag;
                        end else begin
                            case (r_ph)
                                2'd0:    r_lx <= w_idx;
                                2'd1:    r_rx <= w_idx;
                                2'd2:    r_ly <= w_idx;
                                default: r_ry <= w_idx;
                            endcase
                        end
                        r_ph <= r_ph + 1'b1;
                        if (w_last_ph) begin
                            r_state <= r_isq ? S_QF : S_BCHK;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_BCHK: begin
                    if (r_lx <= r_rx && r_ly <= r_ry) begin
                        r_cx    <= r_lx;
                        r_cy    <= r_ly;
                        r_state <= S_CRD;
                    end else if (w_last_box) begin
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_BRD;
                    end
                end
                S_CRD: begin
                    r_state <= S_CWT;
                end
                S_CWT: begin
                    if (r_cy != r_ry) begin
                        r_cy    <= r_cy + 1'b1;
                        r_state <= S_CRD;
                    end else if (r_cx != r_rx) begin
                        r_cx    <= r_cx + 1'b1;
                        r_cy    <= r_ly;
                        r_state <= S_CRD;
                    end else if (w_last_box) begin
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_BRD;
                    end
                end
                S_QF: begin
                    r_state <= S_QFW;
                end
                S_QFW: begin
                    r_n    <= w_fill;
                    r_flag <= w_fill_rd[FCW];
                    r_k    <= '0;
                    if (w_fill == '0) begin
                        r_res   <= '{4'(r_cx), 4'(r_cy), r_outside ? ST_OUTSIDE : ST_INSIDE,
                                     '0, 1'b1, w_fill_rd[FCW], 1'b1};
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_QL;
                    end
                end
                S_QL: begin
                    r_state <= S_QLW;
                end
                S_QLW: begin
                    r_res   <= '{4'(r_cx), 4'(r_cy), r_outside ? ST_OUTSIDE : ST_INSIDE,
                                 w_list_rd, 1'b0, r_flag, (FCW'(r_k) + 1'b1 == r_n)};
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_emit) begin
                        if (r_res.last_result) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_QL;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= r_res;
        end
    end

    assign empty    = !r_out_vld;
    assign o_result = r_out;

    ugb_ram #(.WIDTH(BW), .DEPTH(MAX_BOXES)) u_box_ram (
        .i_clk   (i_clk),
        .i_we    (w_box_we),
        .i_waddr (w_eff[BAW-1:0]),
        .i_wdata ({i_cmd.c0, i_cmd.c1, i_cmd.c2, i_cmd.c3}),
        .i_raddr (r_i),
        .o_rdata (w_box_rd)
    );

    ugb_ram #(.WIDTH(FCW + 1), .DEPTH(NC)) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (w_fill_we),
        .i_waddr (w_fill_wa),
        .i_wdata (w_fill_wd),
        .i_raddr (w_cell),
        .o_rdata (w_fill_rd)
    );

    ugb_ram #(.WIDTH(IDX_BITS), .DEPTH(LD)) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (w_list_we),
        .i_waddr (w_list_wa),
        .i_wdata (IDX_BITS'(r_i)),
        .i_raddr (w_list_ra),
        .o_rdata (w_list_rd)
    );

    ugb_div #(.GRID_SIZE(GRID_SIZE)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_d),
        .i_den   (w_span[COORD_BITS-1:0]),
        .o_stat  (w_div),
        .o_q     (w_div_q)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_BOXES))
        else $error("box count exceeds store depth");

    a_build_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRD || r_state == S_CLR || r_state == S_UMRG) |-> !r_ready)
        else $error("grid marked ready during build");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_res.last_result) |=> (r_state == S_IDLE))
        else $error("query run did not end after its last word");

    a_div_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_DWT))
        else $error("divider finished with no one waiting");

endmodule

// File: rtl/core/uniform_grid_box_binning_core.sv
// Top level of the uniform grid box binning core: front queue plus back end.
// Depends on ugb_pkg, ugb_front and ugb_back (which holds the RAMs and divider).
//
//   channel  | handshake            | word
//   ---------+----------------------+----------------------------------
//   input    | push / full          | i_item   (ugb_pkg::t_item)
//   result   | empty / pop          | o_result (ugb_pkg::t_result)
//
// A load goes into the box store as it leaves the four-word command queue.
// The build clears GRID_SIZE^2 fill counters one per cycle, scans the boxes once,
// reading each and merging it into the union, then per box runs up to four serial
// divisions (one quotient bit per cycle) and enters the box into every covered cell.
// A query runs up to two divisions and reads its cell's fill counter, then reads its
// result words from the cell list, waiting while the result register is not popped.
// Reset is synchronous, active low; the result register holds a word until popped.
`timescale 1ns / 1ps

module uniform_grid_box_binning_core #(
    parameter int GRID_SIZE     = ugb_pkg::DEF_GRID_SIZE,
    parameter int MAX_BOXES     = ugb_pkg::DEF_MAX_BOXES,
    parameter int CELL_CAPACITY = ugb_pkg::DEF_CELL_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  ugb_pkg::t_item   i_item,
    output logic             empty,
    input  logic             pop,
    output ugb_pkg::t_result o_result
);
    import ugb_pkg::*;

    logic w_avail;
    logic w_take;
    t_cmd w_cmd;

    ugb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .i_take  (w_take),
        .o_avail (w_avail),
        .o_cmd   (w_cmd)
    );

    ugb_back #(
        .GRID_SIZE     (GRID_SIZE),
        .MAX_BOXES     (MAX_BOXES),
        .CELL_CAPACITY (CELL_CAPACITY)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (w_avail),
        .o_take   (w_take),
        .i_cmd    (w_cmd),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

endmodule

// File: tb/tb_uniform_grid_box_binning_core.sv
// Self-checking testbench for uniform_grid_box_binning_core: box sets are loaded,
// the grid is rebuilt in a local predictor and query words are checked in order.
// Depends on ugb_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_uniform_grid_box_binning_core;
    import ugb_pkg::*;

    localparam int  GRID      = DEF_GRID_SIZE;
    localparam int  BOX_LIMIT = DEF_MAX_BOXES;
    localparam int  CELL_CAP  = DEF_CELL_CAPACITY;
    localparam int  IDLE_LIMIT = 600000;
    localparam int  DRAIN_CYCLES = 2000;
    localparam longint Q1 = 64'sd65536;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    push = 1'b0;
    logic    full;
    t_item   i_item = '0;
    logic    empty;
    logic    pop = 1'b0;
    t_result o_result;

    uniform_grid_box_binning_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Local copy of the binning state.
    longint  boxes [BOX_LIMIT][4];
    int      n_boxes;
    longint  org_x, org_y, spn_x, spn_y;
    int      fill [GRID*GRID];
    int      lists [GRID*GRID][CELL_CAP];
    bit      overfull [GRID*GRID];
    bit      grid_built;

    t_result expected_words[$];
    t_item   pending_items[$];
    bit      wait_for_drain[$];
    int      errors;

    function automatic longint clamp_cell(longint i);
        if (i < 0) return 0;
        if (i > GRID - 1) return GRID - 1;
        return i;
    endfunction

    function automatic longint cell_of(longint d, longint span);
        return (d * GRID) / span;
    endfunction

    function automatic void bin_boxes();
        longint xmin, xmax, ymin, ymax, lx, rx, ly, ry;
        int c;
        for (int k = 0; k < GRID*GRID; k++) begin
            fill[k] = 0;
            overfull[k] = 0;
        end
        grid_built = 1;
        if (n_boxes == 0) begin
            org_x = 0; org_y = 0; spn_x = 0; spn_y = 0;
            return;
        end
        xmin = boxes[0][0]; xmax = boxes[0][1];
        ymin = boxes[0][2]; ymax = boxes[0][3];
        for (int i = 1; i < n_boxes; i++) begin
            if (boxes[i][0] < xmin) xmin = boxes[i][0];
            if (boxes[i][1] > xmax) xmax = boxes[i][1];
            if (boxes[i][2] < ymin) ymin = boxes[i][2];
            if (boxes[i][3] > ymax) ymax = boxes[i][3];
        end
        org_x = xmin; org_y = ymin;
        spn_x = xmax - xmin; spn_y = ymax - ymin;
        for (int i = 0; i < n_boxes; i++) begin
            lx = 0; rx = 0; ly = 0; ry = 0;
            if (spn_x > 0) begin
                lx = clamp_cell(cell_of(boxes[i][0] - 1 - org_x, spn_x));
                rx = clamp_cell(GRID - cell_of(org_x + spn_x - boxes[i][1] - 1, spn_x) - 1);
            end
            if (spn_y > 0) begin
                ly = clamp_cell(cell_of(boxes[i][2] - 1 - org_y, spn_y));
                ry = clamp_cell(GRID - cell_of(org_y + spn_y - boxes[i][3] - 1, spn_y) - 1);
            end
            for (longint cx = lx; cx <= rx; cx++) begin
                for (longint cy = ly; cy <= ry; cy++) begin
                    c = int'(cx * GRID + cy);
                    if (fill[c] < CELL_CAP) begin
                        lists[c][fill[c]] = i & 10'h3FF;
                        fill[c]++;
                    end else begin
                        overfull[c] = 1;
                    end
                end
            end
        end
    endfunction

    function automatic longint axis_cell(longint q, longint origin, longint span,
                                         ref bit outside);
        longint idx;
        if (span <= 0) begin
            if (q != origin) outside = 1;
            return 0;
        end
        idx = cell_of(q - origin, span);
        if (idx < 0 || idx >= GRID) outside = 1;
        return clamp_cell(idx);
    endfunction

    // Applies one accepted word to the local state and queues the words it yields.
    function automatic void apply_word(t_item it);
        t_result r;
        bit      outside;
        longint  cx, cy;
        int      c;
        if (it.operation == OP_LOAD) begin
            if (grid_built) begin
                grid_built = 0;
                n_boxes = 0;
            end
            if (n_boxes < BOX_LIMIT) begin
                boxes[n_boxes][0] = it.box_x_min;
                boxes[n_boxes][1] = it.box_x_max;
                boxes[n_boxes][2] = it.box_y_min;
                boxes[n_boxes][3] = it.box_y_max;
                n_boxes++;
            end
            if (it.last_box) bin_boxes();
            return;
        end
        r = '0;
        if (!grid_built) begin
            r.status = ST_NOGRID;
            r.cell_empty = 1;
            r.last_result = 1;
            expected_words = {expected_words, r};
            return;
        end
        outside = 0;
        cx = axis_cell(it.query_x, org_x, spn_x, outside);
        cy = axis_cell(it.query_y, org_y, spn_y, outside);
        c = int'(cx * GRID + cy);
        r.cell_x = cx[3:0];
        r.cell_y = cy[3:0];
        r.status = outside ? ST_OUTSIDE : ST_INSIDE;
        r.cell_overflowed = overfull[c];
        if (fill[c] == 0) begin
            r.cell_empty = 1;
            r.last_result = 1;
            expected_words = {expected_words, r};
            return;
        end
        for (int k = 0; k < fill[c]; k++) begin
            r.box_index = lists[c][k][IDX_BITS-1:0];
            r.last_result = (k + 1 == fill[c]);
            expected_words = {expected_words, r};
        end
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: one word in flight on the push side.
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            send_gap <= 0;
        end else begin
            if (push && !full) apply_word(i_item);
            if (push && full) begin
                push <= 1'b1;
            end else if (send_gap > 0) begin
                push <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_items.size() > 0 &&
                         !(wait_for_drain[0] && expected_words.size() > 0)) begin
                push <= 1'b1;
                i_item <= pending_items.pop_front();
                void'(wait_for_drain.pop_front());
                send_gap <= pick_gap();
            end else begin
                push <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Monitor: random pop pressure and in-order comparison of result words.
    int recv_gap;
    always @(posedge i_clk) begin
        t_result w;
        if (!i_rst_n) begin
            pop <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (pop && !empty) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word: %h", o_result);
                    errors++;
                end else begin
                    w = expected_words.pop_front();
                    check_field("cell_x", w.cell_x, o_result.cell_x);
                    check_field("cell_y", w.cell_y, o_result.cell_y);
                    check_field("status", w.status, o_result.status);
                    check_field("box_index", w.box_index, o_result.box_index);
                    check_field("cell_empty", w.cell_empty, o_result.cell_empty);
                    check_field("cell_overflowed", w.cell_overflowed,
                                o_result.cell_overflowed);
                    check_field("last_result", w.last_result, o_result.last_result);
                end
            end
            if (recv_gap > 0) begin
                pop <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                pop <= 1'b1;
                if (pop && !empty) recv_gap <= pick_gap();
            end
        end
    end

    // Watchdog on cycles with no word moving on either side.
    int idle_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("uniform_grid_box_binning_core verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic void add_box(longint x0, longint x1, longint y0, longint y1,
                                    bit last, bit drain = 0);
        t_item it;
        it = '0;
        it.operation = OP_LOAD;
        it.box_x_min = x0[31:0];
        it.box_x_max = x1[31:0];
        it.box_y_min = y0[31:0];
        it.box_y_max = y1[31:0];
        it.last_box = last;
        it.query_x = $urandom();
        it.query_y = $urandom();
        pending_items = {pending_items, it};
        wait_for_drain = {wait_for_drain, drain};
    endfunction

    function automatic void add_query(longint qx, longint qy, bit drain = 0);
        t_item it;
        it = '0;
        it.operation = OP_QUERY;
        it.query_x = qx[31:0];
        it.query_y = qy[31:0];
        it.box_x_min = $urandom();
        it.box_x_max = $urandom();
        it.box_y_min = $urandom();
        it.box_y_max = $urandom();
        it.last_box = $urandom_range(0, 1);
        pending_items = {pending_items, it};
        wait_for_drain = {wait_for_drain, drain};
    endfunction

    function automatic longint any_coord();
        return longint'($signed($urandom()));
    endfunction

    function automatic longint near_coord();
        return longint'($urandom_range(0, 64 * 65536)) - 32 * Q1;
    endfunction

    initial begin
        longint lo_x, hi_x, lo_y, hi_y, x0, y0, bx_lo, bx_hi, by_lo, by_hi;
        int     n;
        errors = 0;
        n_boxes = 0;
        grid_built = 0;
        org_x = 0; org_y = 0; spn_x = 0; spn_y = 0;
        for (int k = 0; k < GRID*GRID; k++) begin
            fill[k] = 0;
            overfull[k] = 0;
        end

        // Directed part.
        add_query(0, 0);
        add_box(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647, 0);
        add_box(0, Q1, -Q1, 0, 1);
        add_query(-64'sd2147483648, 64'sd2147483647);
        add_query(64'sd2147483647, -64'sd2147483648);
        add_query(Q1 / 2, -Q1 / 2);
        add_box(5 * Q1, 5 * Q1, 3 * Q1, 3 * Q1, 1);
        add_query(5 * Q1, 3 * Q1);
        add_query(5 * Q1 + 1, 3 * Q1);
        add_box(4 * Q1, -4 * Q1, 2 * Q1, -2 * Q1, 1);
        add_query(4 * Q1, 2 * Q1);
        add_box(0, Q1, 0, Q1, 0);
        add_box(15 * Q1, 16 * Q1, 15 * Q1, 16 * Q1, 1);
        add_query(8 * Q1, 8 * Q1);
        add_query(-1, 0);
        add_query(16 * Q1, 16 * Q1);
        add_query(17 * Q1, -3 * Q1);
        for (int i = 0; i < 20; i++) add_box(0, 16 * Q1, 0, 16 * Q1, i == 19, i == 0);
        add_query(3 * Q1, 9 * Q1);

        // Random box sets, each followed by queries.
        while (pending_items.size() < 360) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 8);
            lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 5) == 0) begin
                    bx_lo = any_coord(); bx_hi = any_coord();
                    by_lo = any_coord(); by_hi = any_coord();
                end else begin
                    bx_lo = near_coord(); by_lo = near_coord();
                    bx_hi = bx_lo + $urandom_range(0, 20 * 65536);
                    by_hi = by_lo + $urandom_range(0, 20 * 65536);
                    if (bx_hi > 64'sd2147483647) bx_hi = 64'sd2147483647;
                    if (by_hi > 64'sd2147483647) by_hi = 64'sd2147483647;
                end
                if (i == 0 || bx_lo < lo_x) lo_x = bx_lo;
                if (i == 0 || bx_hi > hi_x) hi_x = bx_hi;
                if (i == 0 || by_lo < lo_y) lo_y = by_lo;
                if (i == 0 || by_hi > hi_y) hi_y = by_hi;
                add_box(bx_lo, bx_hi, by_lo, by_hi, i == n - 1);
                if ($urandom_range(0, 19) == 0) add_query(near_coord(), near_coord());
            end
            n = $urandom_range(2, 12);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    add_query(any_coord(), any_coord());
                end else begin
                    x0 = lo_x + longint'($urandom()) % (hi_x - lo_x + 1 + Q1);
                    y0 = lo_y + longint'($urandom()) % (hi_y - lo_y + 1 + Q1);
                    if (x0 > 64'sd2147483647) x0 = 64'sd2147483647;
                    if (y0 > 64'sd2147483647) y0 = 64'sd2147483647;
                    add_query(x0, y0);
                end
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0 && !push && expected_words.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("uniform_grid_box_binning_core verification clean");
        end else begin
            $display("uniform_grid_box_binning_core verification failed");
        end
        $finish;
    end

endmodule
